>>> hw/rtl/keyed_ordered_list_store_core_assert.svh
// Assertion macros for the keyed ordered list store.
// Both sample on the rising edge of clk and are disabled while rst_n is low.
// IMP: consequence holds in the same cycle. NXT: consequence holds in the next cycle.
`ifndef KEYED_ORDERED_LIST_STORE_CORE_ASSERT_SVH
`define KEYED_ORDERED_LIST_STORE_CORE_ASSERT_SVH
`ifndef SYNTH
`define KOLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kols: same-cycle check failed");
`define KOLS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kols: next-cycle check failed");
`else
`define KOLS_ASSERT_IMP(lbl, ante, cons)
`define KOLS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/kols_pkg.sv
package kols_pkg;

    localparam int OP_W       = 3;
    localparam int IN_KEY_W   = 64;
    localparam int SCORE_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int TOTAL_W    = 20;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_POP       = 3'd2,
        OP_LOOKUP    = 3'd3,
        OP_REMOVE    = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_LINK,
        SEQ_POP,
        SEQ_WALK,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed {
        status_t              status;
        logic [IN_KEY_W-1:0]  found_key;
        logic [SCORE_W-1:0]   found_score;
        logic [COUNT_W-1:0]   entry_count;
        logic [TOTAL_W-1:0]   score_total;
    } result_t;

endpackage

>>> hw/rtl/kols_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module kols_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/kols_slot_alloc.sv
// Free-slot bitmap; hands out the lowest free slot.
module kols_slot_alloc #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take_en,
    input  logic                          release_en,
    input  logic [$clog2(LIST_DEPTH)-1:0] release_slot,
    output logic [$clog2(LIST_DEPTH)-1:0] free_slot
);

    localparam int AW = $clog2(LIST_DEPTH);

    logic [LIST_DEPTH-1:0] free_reg;
    logic [LIST_DEPTH-1:0] free_next;
    logic [LIST_DEPTH-1:0] lowest;

    // isolate lowest set bit, then encode the one-hot
    assign lowest = free_reg & (~free_reg + LIST_DEPTH'(1));

    always_comb
    begin
        free_slot = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (lowest[i])
            begin
                free_slot = free_slot | AW'(i);
            end
        end
    end

    always_comb
    begin
        free_next = free_reg;
        if (take_en)
        begin
            free_next[free_slot] = 1'b0;
        end
        if (release_en)
        begin
            free_next[release_slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
        end
        else
        begin
            free_reg <= free_next;
        end
    end

endmodule

>>> hw/rtl/kols_seq.sv
// Operation sequencer: list pointers, counters and the linked walk.
module kols_seq #(
    parameter int LIST_DEPTH = 16,
    parameter int KEY_BITS   = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [kols_pkg::OP_W-1:0]        req_op,
    input  logic [kols_pkg::IN_KEY_W-1:0]    req_key,
    input  logic [kols_pkg::SCORE_W-1:0]     req_score,
    output logic                             res_valid,
    input  logic                             res_take,
    output kols_pkg::result_t                res
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = kols_pkg::SCORE_W;
    localparam int TW = kols_pkg::TOTAL_W;
    localparam int DW = KEY_BITS + SW;

    kols_pkg::seq_state_t state_reg, state_next;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [TW-1:0] total_reg, total_next;
    logic [CW-1:0] step_reg, step_next;

    logic [kols_pkg::OP_W-1:0] op_reg, op_next;
    logic [KEY_BITS-1:0]       key_reg, key_next;
    logic [SW-1:0]             score_reg, score_next;
    logic [AW-1:0]             cur_reg, cur_next;
    logic [AW-1:0]             prev_reg, prev_next;
    logic [AW-1:0]             slot_reg, slot_next;
    kols_pkg::status_t         rstat_reg, rstat_next;
    logic [kols_pkg::IN_KEY_W-1:0] rkey_reg, rkey_next;
    logic [SW-1:0]             rscore_reg, rscore_next;

    logic          data_we;
    logic [AW-1:0] data_wa;
    logic          link_we;
    logic [AW-1:0] link_wa;
    logic [AW-1:0] link_wd;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] data_rd;
    logic [AW-1:0] link_rd;
    logic [KEY_BITS-1:0] rd_key;
    logic [SW-1:0] rd_score;

    logic          take_en;
    logic          rel_en;
    logic [AW-1:0] alloc_slot;

    kols_ram #(.WIDTH(DW), .DEPTH(LIST_DEPTH)) u_data_ram (
        .clk     (clk),
        .wr_en   (data_we),
        .wr_addr (data_wa),
        .wr_data ({key_reg, score_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (data_rd)
    );

    kols_ram #(.WIDTH(AW), .DEPTH(LIST_DEPTH)) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_wa),
        .wr_data (link_wd),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (link_rd)
    );

    kols_slot_alloc #(.LIST_DEPTH(LIST_DEPTH)) u_alloc (
        .clk          (clk),
        .rst_n        (rst_n),
        .take_en      (take_en),
        .release_en   (rel_en),
        .release_slot (cur_reg),
        .free_slot    (alloc_slot)
    );

    assign rd_key   = data_rd[DW-1:SW];
    assign rd_score = data_rd[SW-1:0];

    assign res.status      = rstat_reg;
    assign res.found_key   = rkey_reg;
    assign res.found_score = rscore_reg;
    assign res.entry_count = kols_pkg::COUNT_W'(count_reg);
    assign res.score_total = total_reg;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        step_next   = step_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        score_next  = score_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        slot_next   = slot_reg;
        rstat_next  = rstat_reg;
        rkey_next   = rkey_reg;
        rscore_next = rscore_reg;
        data_we     = 1'b0;
        data_wa     = alloc_slot;
        link_we     = 1'b0;
        link_wa     = alloc_slot;
        link_wd     = '0;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        take_en     = 1'b0;
        rel_en      = 1'b0;
        req_ready   = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            kols_pkg::SEQ_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = req_op;
                    key_next   = KEY_BITS'(req_key);
                    score_next = req_score;
                    state_next = kols_pkg::SEQ_START;
                end
            end

            kols_pkg::SEQ_START:
            begin
                rstat_next  = kols_pkg::ST_OK;
                rkey_next   = '0;
                rscore_next = '0;
                state_next  = kols_pkg::SEQ_DONE;
                case (op_reg)
                    kols_pkg::OP_INS_FRONT, kols_pkg::OP_INS_BACK:
                    begin
                        if (count_reg == CW'(LIST_DEPTH))
                        begin
                            rstat_next = kols_pkg::ST_FULL;
                        end
                        else
                        begin
                            data_we    = 1'b1;
                            link_we    = 1'b1;
                            take_en    = 1'b1;
                            count_next = count_reg + CW'(1);
                            total_next = total_reg + TW'(score_reg);
                            if (op_reg == kols_pkg::OP_INS_FRONT && count_reg != '0)
                            begin
                                link_wd = head_reg;
                            end
                            if (count_reg == '0)
                            begin
                                head_next = alloc_slot;
                                tail_next = alloc_slot;
                            end
                            else if (op_reg == kols_pkg::OP_INS_FRONT)
                            begin
                                head_next = alloc_slot;
                            end
                            else
                            begin
                                slot_next  = alloc_slot;
                                state_next = kols_pkg::SEQ_LINK;
                            end
                        end
                    end
                    kols_pkg::OP_POP, kols_pkg::OP_LOOKUP, kols_pkg::OP_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            rstat_next = kols_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = head_reg;
                            cur_next  = head_reg;
                            prev_next = head_reg;
                            step_next = '0;
                            if (op_reg == kols_pkg::OP_POP)
                            begin
                                state_next = kols_pkg::SEQ_POP;
                            end
                            else
                            begin
                                state_next = kols_pkg::SEQ_WALK;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            kols_pkg::SEQ_LINK:
            begin
                // hook the new tail onto the old one
                link_we    = 1'b1;
                link_wa    = tail_reg;
                link_wd    = slot_reg;
                tail_next  = slot_reg;
                state_next = kols_pkg::SEQ_DONE;
            end

            kols_pkg::SEQ_POP:
            begin
                rkey_next   = kols_pkg::IN_KEY_W'(rd_key);
                rscore_next = rd_score;
                head_next   = link_rd;
                rel_en      = 1'b1;
                total_next  = total_reg - TW'(rd_score);
                count_next  = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                state_next = kols_pkg::SEQ_DONE;
            end

            kols_pkg::SEQ_WALK:
            begin
                if (rd_key == key_reg)
                begin
                    state_next = kols_pkg::SEQ_DONE;
                    if (op_reg == kols_pkg::OP_LOOKUP)
                    begin
                        rscore_next = rd_score;
                    end
                    else
                    begin
                        if (cur_reg == head_reg)
                        begin
                            head_next = link_rd;
                        end
                        else
                        begin
                            link_we = 1'b1;
                            link_wa = prev_reg;
                            link_wd = link_rd;
                            if (cur_reg == tail_reg)
                            begin
                                tail_next = prev_reg;
                            end
                        end
                        rel_en     = 1'b1;
                        total_next = total_reg - TW'(rd_score);
                        count_next = count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                    end
                end
                else if ((step_reg + CW'(1)) == count_reg)
                begin
                    rstat_next = kols_pkg::ST_MISSING;
                    state_next = kols_pkg::SEQ_DONE;
                end
                else
                begin
                    // follow the link straight from the read port
                    prev_next = cur_reg;
                    cur_next  = link_rd;
                    rd_en     = 1'b1;
                    rd_addr   = link_rd;
                    step_next = step_reg + CW'(1);
                end
            end

            kols_pkg::SEQ_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = kols_pkg::SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = kols_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kols_pkg::SEQ_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            total_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            total_reg <= total_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        score_reg  <= score_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        slot_reg   <= slot_next;
        rstat_reg  <= rstat_next;
        rkey_reg   <= rkey_next;
        rscore_reg <= rscore_next;
    end

endmodule

>>> hw/rtl/keyed_ordered_list_store_core.sv
// Keyed ordered list store: a bounded singly linked list of up to LIST_DEPTH
// entries (key plus unsigned Q8.8 score) kept in two registered-read RAMs,
// one for key/score and one for next links, with a free-slot bitmap that
// always hands out the lowest free slot. One request is worked at a time;
// a new request is taken as soon as the previous result sits in the output
// register. From accept to result ready, insert front passes the START and
// DONE states, insert back onto a non-empty list adds LINK, pop adds POP,
// and lookup/remove add one WALK step per entry up to the first match, or
// per entry on a miss. The walk follows one link per cycle, fed straight
// from the link RAM read port, so its length sets the worst case. Codes 5
// to 7 answer ok with no change. No clearing pass after reset.
`include "keyed_ordered_list_store_core_assert.svh"

module keyed_ordered_list_store_core #(
    parameter int LIST_DEPTH = 16,
    parameter int KEY_BITS   = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [63:0] entry_key,
    input  logic [15:0] entry_score,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] found_key,
    output logic [15:0] found_score,
    output logic [4:0]  entry_count,
    output logic [19:0] score_total
);

    logic              req_ready;
    logic              res_valid;
    logic              res_take;
    kols_pkg::result_t res;

    logic              out_valid_reg, out_valid_next;
    kols_pkg::result_t out_res_reg, out_res_next;

    // sequencer owns all list state; this level only adds the output stage
    kols_seq #(
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_BITS   (KEY_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (req_ready),
        .req_op    (operation),
        .req_key   (entry_key),
        .req_score (entry_score),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign in_stall = !req_ready;

    // output register frees up whenever it is empty or being drained
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign found_key   = out_res_reg.found_key;
    assign found_score = out_res_reg.found_score;
    assign entry_count = out_res_reg.entry_count;
    assign score_total = out_res_reg.score_total;

    // Checks: status codes agree with the reported occupancy, error results
    // report no found entry, and the sequencer goes busy right after taking a request.
    `KOLS_ASSERT_IMP(a_full_count, out_valid && status == kols_pkg::ST_FULL, entry_count == 5'(LIST_DEPTH))
    `KOLS_ASSERT_IMP(a_empty_zero, out_valid && status == kols_pkg::ST_EMPTY, entry_count == 5'd0 && score_total == 20'd0)
    `KOLS_ASSERT_IMP(a_err_no_data, out_valid && status != kols_pkg::ST_OK, found_key == 64'd0 && found_score == 16'd0)
    `KOLS_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall)

endmodule
